@@ rtl/msie_pkg.sv @@
// Shared constants, codes and types for the MIPS subset execute block.
package msie_pkg;

    // Data memory geometry: four byte lanes, one row holds one aligned word.
    localparam int MEM_BYTES = 1024;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int ROWS      = MEM_BYTES / 4;
    localparam int ROW_AW    = MEM_AW - 2;

    // Item modes.
    typedef enum logic [1:0] {
        MODE_EXEC    = 2'd0,
        MODE_PRELOAD = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam logic CFG_START_PC = 1'b0;
    localparam logic CFG_START_SP = 1'b1;

    // Fixed register numbers and PC region mask.
    localparam logic [4:0]  REG_SP      = 5'd29;
    localparam logic [4:0]  REG_RA      = 5'd31;
    localparam logic [31:0] PC_TOP_MASK = 32'hF000_0000;

    // Primary opcodes.
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_BGTZ  = 6'h07;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0a;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_NORI  = 6'h0e;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_LH    = 6'h21;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_LBU   = 6'h24;
    localparam logic [5:0] OP_LHU   = 6'h25;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SW    = 6'h2b;
    localparam logic [5:0] OP_HALT  = 6'h3f;

    // R-type function codes.
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_NAND  = 6'h28;
    localparam logic [5:0] FN_SLT   = 6'h2a;

    // Access size of a data memory request.
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } size_t;

    // Request from the execute control to the data memory.
    typedef struct packed {
        logic              en;
        logic              we;
        logic              clear;
        logic [MEM_AW-1:0] addr;
        size_t             size;
        logic [31:0]       wdata;
        logic [ROW_AW-1:0] clr_row;
    } dmem_req_t;

endpackage

@@ rtl/msie_rf.sv @@
// General register file: two synchronous memory copies with valid bits.
module msie_rf
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [4:0]  ra_a,
    input  logic [4:0]  ra_b,
    input  logic [4:0]  ra_d,
    input  logic        we,
    input  logic [4:0]  wa,
    input  logic [31:0] wd,
    input  logic        clr,
    output logic [31:0] a,
    output logic [31:0] b,
    output logic [31:0] d
);

    logic [31:0] mem_ab [32];
    logic [31:0] mem_d  [32];
    logic [31:0] valid_reg;
    logic [31:0] valid_next;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] d_reg;
    logic        wr_ok;

    assign wr_ok = we && (wa != 5'd0);

    // Read value with write-first forwarding; cleared or unwritten entries read zero.
    function automatic logic [31:0] pick(input logic [4:0] idx, input logic [31:0] raw);
        logic [31:0] v;
        if (wr_ok && (wa == idx))
        begin
            v = wd;
        end
        else if (clr || !valid_reg[idx])
        begin
            v = 32'd0;
        end
        else
        begin
            v = raw;
        end
        return v;
    endfunction

    // Valid bits: restart clears them, every write sets its own.
    always_comb
    begin
        valid_next = clr ? 32'd0 : valid_reg;
        if (wr_ok)
        begin
            valid_next[wa] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 32'd0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Storage writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem_ab[wa] <= wd;
            mem_d[wa]  <= wd;
        end
        if (rd_en)
        begin
            a_reg <= pick(ra_a, mem_ab[ra_a]);
            b_reg <= pick(ra_b, mem_ab[ra_b]);
            d_reg <= pick(ra_d, mem_d[ra_d]);
        end
    end

    assign a = a_reg;
    assign b = b_reg;
    assign d = d_reg;

endmodule

@@ rtl/msie_dmem.sv @@
// Big-endian byte data memory built from four byte-lane synchronous memories.
module msie_dmem
(
    input  logic                clk,
    input  msie_pkg::dmem_req_t req,
    output logic [31:0]         rdata
);

    logic [7:0]       lane_q [4];
    logic [1:0]       lo_q;
    msie_pkg::size_t  size_q;
    logic [7:0]       byte_v [4];

    // Each lane serves the one byte of the access that falls on it.
    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        logic [7:0]                  mem [msie_pkg::ROWS];
        logic [1:0]                  off;
        logic [msie_pkg::MEM_AW-1:0] la;
        logic                        sel;
        logic [7:0]                  wb;

        always_comb
        begin
            off = 2'(k) - req.addr[1:0];
            la  = req.addr + msie_pkg::MEM_AW'(off);
            unique case (req.size)
                msie_pkg::SZ_WORD:
                begin
                    sel = 1'b1;
                    wb  = req.wdata[{2'd3 - off, 3'b000} +: 8];
                end
                msie_pkg::SZ_HALF:
                begin
                    sel = (off[1] == 1'b0);
                    wb  = req.wdata[{~off[0], 3'b000} +: 8];
                end
                msie_pkg::SZ_BYTE:
                begin
                    sel = (off == 2'd0);
                    wb  = req.wdata[7:0];
                end
                default:
                begin
                    sel = 1'b0;
                    wb  = req.wdata[7:0];
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (req.clear)
            begin
                mem[req.clr_row] <= 8'd0;
            end
            else if (req.en && req.we && sel)
            begin
                mem[la[msie_pkg::MEM_AW-1:2]] <= wb;
            end
            if (req.en && !req.we)
            begin
                lane_q[k] <= mem[la[msie_pkg::MEM_AW-1:2]];
            end
        end
    end

    // Remember alignment and size of the pending read.
    always_ff @(posedge clk)
    begin
        if (req.en && !req.we)
        begin
            lo_q   <= req.addr[1:0];
            size_q <= req.size;
        end
    end

    // Reorder lanes into access byte order and right-justify.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            byte_v[i] = lane_q[2'(lo_q + 2'(i))];
        end
        unique case (size_q)
            msie_pkg::SZ_WORD: rdata = {byte_v[0], byte_v[1], byte_v[2], byte_v[3]};
            msie_pkg::SZ_HALF: rdata = {16'd0, byte_v[0], byte_v[1]};
            msie_pkg::SZ_BYTE: rdata = {24'd0, byte_v[0]};
            default:           rdata = {24'd0, byte_v[0]};
        endcase
    end

endmodule

@@ rtl/mips_subset_instruction_execute_top.sv @@
// Top level of the MIPS subset execute block: control, datapath and state.
// The register file is read at the edge that accepts a word, and the item
// executes in the next cycle and writes back when it finishes; its result is
// then presented from the output registers. Loads pass through a further load
// state, since the data memory read is synchronous too. A new word is accepted in
// the cycle that the previous item finishes, so plain instructions sustain one
// word per cycle while the output is not stalled, and a load holds the input
// during its load state; a stalled output holds the item in flight and the input.
// After reset the data memory is cleared one row per cycle through every row;
// no word is accepted then, configuration writes are. A finished result sits in
// an output register while the next word executes.
module mips_subset_instruction_execute_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] word,
    input  logic [9:0]  preload_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] next_pc,
    output logic [33:0] changed_mask,
    output logic        halted,
    output logic        illegal
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_LOAD  = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [msie_pkg::ROW_AW-1:0] clr_row_reg;
    logic [31:0]                 word_reg;
    msie_pkg::mode_t             mode_reg;
    logic [9:0]                  paddr_reg;
    logic [4:0]                  dest_reg;
    logic [31:0]                 pc_reg, pc_next;
    logic [31:0]                 hi_reg, hi_next;
    logic [31:0]                 lo_reg, lo_next;
    logic                        halted_reg, illegal_reg;
    logic [31:0]                 start_pc_reg, start_sp_reg;
    logic                        out_valid_reg;
    logic [31:0]                 out_pc_reg;
    logic [33:0]                 out_mask_reg;
    logic                        out_halted_reg, out_illegal_reg;

    logic        accept, out_free, finish, go_load, legal;
    logic [4:0]  in_dest;
    logic [31:0] ra, rb, rdv;
    logic        rf_we_c, rf_clr_c, hilo_we, halt_set, ill_set, flag_clr;
    logic [31:0] rf_wd;
    logic [4:0]  rf_wa;
    logic [33:0] mask_next;
    logic        halted_next, illegal_next;
    logic [31:0] mem_rdata, load_val;
    msie_pkg::dmem_req_t mreq_c, mreq;

    // Instruction fields of the word in flight.
    logic [5:0]  op, fn;
    logic [4:0]  sh;
    logic [31:0] simm, zimm, ea, pc4, jtarget;
    logic signed [63:0] prod_s;
    logic [63:0]        prod_u;

    assign op      = word_reg[31:26];
    assign fn      = word_reg[5:0];
    assign sh      = word_reg[10:6];
    assign zimm    = {16'd0, word_reg[15:0]};
    assign simm    = {{16{word_reg[15]}}, word_reg[15:0]};
    assign ea      = ra + simm;
    assign pc4     = pc_reg + 32'd4;
    assign jtarget = (pc4 & msie_pkg::PC_TOP_MASK) | {4'd0, word_reg[25:0], 2'b00};
    assign prod_s  = $signed(ra) * $signed(rb);
    assign prod_u  = ra * rb;

    // Handshake: a word enters when idle or in the cycle the previous one finishes.
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = out_free && (((state_reg == S_EXEC) && !go_load) || (state_reg == S_LOAD));
    assign in_stall = !((state_reg == S_IDLE) || finish);
    assign accept   = in_valid && !in_stall;

    // Destination register of an incoming instruction, read for change detection.
    assign in_dest = (word[31:26] == msie_pkg::OP_RTYPE) ? word[15:11] :
                     (word[31:26] == msie_pkg::OP_JAL)   ? msie_pkg::REG_RA : word[20:16];

    // Load data extension.
    always_comb
    begin
        unique case (op)
            msie_pkg::OP_LH: load_val = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
            msie_pkg::OP_LB: load_val = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
            default:         load_val = mem_rdata;
        endcase
    end

    // Execute decode: every effect of the item, committed only when it finishes.
    always_comb
    begin
        rf_we_c      = 1'b0;
        rf_wa        = dest_reg;
        rf_wd        = 32'd0;
        rf_clr_c     = 1'b0;
        hilo_we      = 1'b0;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        pc_next      = pc_reg;
        halt_set     = 1'b0;
        ill_set      = 1'b0;
        flag_clr     = 1'b0;
        go_load      = 1'b0;
        legal        = 1'b1;
        mreq_c       = '0;
        mreq_c.addr  = ea[msie_pkg::MEM_AW-1:0];
        mreq_c.size  = msie_pkg::SZ_WORD;
        mreq_c.wdata = rb;
        unique case (mode_reg)
            msie_pkg::MODE_EXEC:
            begin
                if (!halted_reg && !illegal_reg)
                begin
                    pc_next = pc4;
                    if (op == msie_pkg::OP_RTYPE)
                    begin
                        rf_we_c = 1'b1;
                        unique case (fn)
                            msie_pkg::FN_ADD, msie_pkg::FN_ADDU: rf_wd = ra + rb;
                            msie_pkg::FN_SUB:  rf_wd = ra - rb;
                            msie_pkg::FN_AND:  rf_wd = ra & rb;
                            msie_pkg::FN_OR:   rf_wd = ra | rb;
                            msie_pkg::FN_XOR:  rf_wd = ra ^ rb;
                            msie_pkg::FN_NOR:  rf_wd = ~(ra | rb);
                            msie_pkg::FN_NAND: rf_wd = ~(ra & rb);
                            msie_pkg::FN_SLT:  rf_wd = {31'd0, $signed(ra) < $signed(rb)};
                            msie_pkg::FN_SLL:  rf_wd = rb << sh;
                            msie_pkg::FN_SRL:  rf_wd = rb >> sh;
                            msie_pkg::FN_SRA:  rf_wd = 32'($signed(rb) >>> sh);
                            msie_pkg::FN_MFHI: rf_wd = hi_reg;
                            msie_pkg::FN_MFLO: rf_wd = lo_reg;
                            msie_pkg::FN_JR:
                            begin
                                rf_we_c = 1'b0;
                                pc_next = ra;
                            end
                            msie_pkg::FN_MULT:
                            begin
                                rf_we_c = 1'b0;
                                hilo_we = 1'b1;
                                hi_next = prod_s[63:32];
                                lo_next = prod_s[31:0];
                            end
                            msie_pkg::FN_MULTU:
                            begin
                                rf_we_c = 1'b0;
                                hilo_we = 1'b1;
                                hi_next = prod_u[63:32];
                                lo_next = prod_u[31:0];
                            end
                            default: legal = 1'b0;
                        endcase
                    end
                    else
                    begin
                        unique case (op)
                            msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU:
                            begin
                                rf_we_c = 1'b1;
                                rf_wd   = ra + simm;
                            end
                            msie_pkg::OP_LUI:
                            begin
                                rf_we_c = 1'b1;
                                rf_wd   = {word_reg[15:0], 16'd0};
                            end
                            msie_pkg::OP_ANDI:
                            begin
                                rf_we_c = 1'b1;
                                rf_wd   = ra & zimm;
                            end
                            msie_pkg::OP_ORI:
                            begin
                                rf_we_c = 1'b1;
                                rf_wd   = ra | zimm;
                            end
                            msie_pkg::OP_NORI:
                            begin
                                rf_we_c = 1'b1;
                                rf_wd   = ~(ra | zimm);
                            end
                            msie_pkg::OP_SLTI:
                            begin
                                rf_we_c = 1'b1;
                                rf_wd   = {31'd0, $signed(ra) < $signed(simm)};
                            end
                            msie_pkg::OP_LW, msie_pkg::OP_LH, msie_pkg::OP_LHU,
                            msie_pkg::OP_LB, msie_pkg::OP_LBU:
                            begin
                                rf_we_c   = 1'b1;
                                rf_wd     = load_val;
                                go_load   = (state_reg == S_EXEC);
                                mreq_c.en = 1'b1;
                                if (op == msie_pkg::OP_LW)
                                begin
                                    mreq_c.size = msie_pkg::SZ_WORD;
                                end
                                else if ((op == msie_pkg::OP_LH) || (op == msie_pkg::OP_LHU))
                                begin
                                    mreq_c.size = msie_pkg::SZ_HALF;
                                end
                                else
                                begin
                                    mreq_c.size = msie_pkg::SZ_BYTE;
                                end
                            end
                            msie_pkg::OP_SW:
                            begin
                                mreq_c.en = 1'b1;
                                mreq_c.we = 1'b1;
                            end
                            msie_pkg::OP_SH:
                            begin
                                mreq_c.en   = 1'b1;
                                mreq_c.we   = 1'b1;
                                mreq_c.size = msie_pkg::SZ_HALF;
                            end
                            msie_pkg::OP_SB:
                            begin
                                mreq_c.en   = 1'b1;
                                mreq_c.we   = 1'b1;
                                mreq_c.size = msie_pkg::SZ_BYTE;
                            end
                            msie_pkg::OP_BEQ:
                            begin
                                if (ra == rb)
                                begin
                                    pc_next = pc4 + {simm[29:0], 2'b00};
                                end
                            end
                            msie_pkg::OP_BNE:
                            begin
                                if (ra != rb)
                                begin
                                    pc_next = pc4 + {simm[29:0], 2'b00};
                                end
                            end
                            msie_pkg::OP_BGTZ:
                            begin
                                if (!ra[31] && (ra != 32'd0))
                                begin
                                    pc_next = pc4 + {simm[29:0], 2'b00};
                                end
                            end
                            msie_pkg::OP_J: pc_next = jtarget;
                            msie_pkg::OP_JAL:
                            begin
                                rf_we_c = 1'b1;
                                rf_wd   = pc4;
                                pc_next = jtarget;
                            end
                            msie_pkg::OP_HALT: halt_set = 1'b1;
                            default: legal = 1'b0;
                        endcase
                    end
                    // An undefined word leaves everything but the illegal flag alone.
                    if (!legal)
                    begin
                        ill_set   = 1'b1;
                        pc_next   = pc_reg;
                        rf_we_c   = 1'b0;
                        hilo_we   = 1'b0;
                        mreq_c.en = 1'b0;
                        go_load   = 1'b0;
                    end
                end
            end
            msie_pkg::MODE_PRELOAD:
            begin
                mreq_c.en    = 1'b1;
                mreq_c.we    = 1'b1;
                mreq_c.addr  = msie_pkg::MEM_AW'({22'd0, paddr_reg[9:2], 2'b00});
                mreq_c.wdata = word_reg;
            end
            msie_pkg::MODE_RESTART:
            begin
                rf_clr_c = 1'b1;
                rf_we_c  = 1'b1;
                rf_wa    = msie_pkg::REG_SP;
                rf_wd    = start_sp_reg;
                hilo_we  = 1'b1;
                hi_next  = 32'd0;
                lo_next  = 32'd0;
                pc_next  = start_pc_reg;
                flag_clr = 1'b1;
            end
            default:
            begin
                pc_next = pc_reg;
            end
        endcase
    end

    // Change mask: only executed instructions report changes.
    always_comb
    begin
        mask_next = 34'd0;
        if (mode_reg == msie_pkg::MODE_EXEC)
        begin
            if (rf_we_c && (rf_wa != 5'd0) && (rf_wd != rdv))
            begin
                mask_next[rf_wa] = 1'b1;
            end
            if (hilo_we && (hi_next != hi_reg))
            begin
                mask_next[32] = 1'b1;
            end
            if (hilo_we && (lo_next != lo_reg))
            begin
                mask_next[33] = 1'b1;
            end
        end
    end

    assign halted_next  = !flag_clr && (halted_reg || halt_set);
    assign illegal_next = !flag_clr && (illegal_reg || ill_set);

    // Memory request: clearing pass, reads freely, writes only on finish.
    always_comb
    begin
        mreq         = mreq_c;
        mreq.clear   = (state_reg == S_CLEAR);
        mreq.clr_row = clr_row_reg;
        if ((state_reg != S_EXEC) && (state_reg != S_LOAD))
        begin
            mreq.en = 1'b0;
        end
        if (mreq_c.we && !finish)
        begin
            mreq.en = 1'b0;
        end
    end

    msie_rf u_rf
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .ra_a  (word[25:21]),
        .ra_b  (word[20:16]),
        .ra_d  (in_dest),
        .we    (rf_we_c && finish),
        .wa    (rf_wa),
        .wd    (rf_wd),
        .clr   (rf_clr_c && finish),
        .a     (ra),
        .b     (rb),
        .d     (rdv)
    );

    msie_dmem u_dmem
    (
        .clk   (clk),
        .req   (mreq),
        .rdata (mem_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_row_reg == {msie_pkg::ROW_AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (go_load)
                begin
                    state_next = S_LOAD;
                end
                else if (finish)
                begin
                    state_next = accept ? S_EXEC : S_IDLE;
                end
            end
            S_LOAD:
            begin
                if (finish)
                begin
                    state_next = accept ? S_EXEC : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_row_reg   <= '0;
            pc_reg        <= 32'd0;
            hi_reg        <= 32'd0;
            lo_reg        <= 32'd0;
            halted_reg    <= 1'b0;
            illegal_reg   <= 1'b0;
            start_pc_reg  <= 32'd0;
            start_sp_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
            if (cfg_write)
            begin
                if (cfg_index == msie_pkg::CFG_START_PC)
                begin
                    start_pc_reg <= cfg_data;
                end
                else
                begin
                    start_sp_reg <= cfg_data;
                end
            end
            if (finish)
            begin
                pc_reg      <= pc_next;
                halted_reg  <= halted_next;
                illegal_reg <= illegal_next;
                if (hilo_we)
                begin
                    hi_reg <= hi_next;
                    lo_reg <= lo_next;
                end
            end
            out_valid_reg <= finish || (out_valid_reg && out_stall);
        end
    end

    // Item and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg  <= word;
            mode_reg  <= msie_pkg::mode_t'(mode);
            paddr_reg <= preload_address;
            dest_reg  <= in_dest;
        end
        if (finish)
        begin
            out_pc_reg      <= pc_next;
            out_mask_reg    <= mask_next;
            out_halted_reg  <= halted_next;
            out_illegal_reg <= illegal_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = out_pc_reg;
    assign changed_mask = out_mask_reg;
    assign halted       = out_halted_reg;
    assign illegal      = out_illegal_reg;

    // No word enters during the memory clearing pass.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("word accepted during memory clear");

    // A finished item always presents a result next cycle.
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid)
        else $error("finished item without result");

    // The load state is only entered from execute or held.
    a_load_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> ($past(state_reg) == S_EXEC) || ($past(state_reg) == S_LOAD))
        else $error("load state entered out of order");

endmodule

@@ tb/mips_subset_instruction_execute_top_tb.sv @@
// Self-checking testbench for the MIPS subset execute block.
`timescale 1ns / 100ps

module mips_subset_instruction_execute_top_tb;

    // One result word of the block.
    typedef struct packed {
        logic [31:0] pc;
        logic [33:0] msk;
        logic        h;
        logic        il;
    } exec_result_t;

    // One row of the directed program; typed rows carry their own expected word.
    typedef struct packed {
        logic [1:0]   m;
        logic [31:0]  w;
        logic [9:0]   pa;
        logic         typed;
        exec_result_t r;
    } prog_row_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIR_ROWS       = 29;
    localparam int PHASE_ITEMS    = 255;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [31:0] word;
    logic [9:0]  preload_address;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] next_pc;
    logic [33:0] changed_mask;
    logic        halted;
    logic        illegal;

    mips_subset_instruction_execute_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .word(word), .preload_address(preload_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .next_pc(next_pc), .changed_mask(changed_mask),
        .halted(halted), .illegal(illegal)
    );

    // Machine state as the predictor sees it.
    logic [31:0] gpr [0:31];
    logic [31:0] hi_q, lo_q, pc_q;
    logic [7:0]  dmem [0:msie_pkg::MEM_BYTES-1];
    logic        st_halt, st_ill;
    logic [31:0] cfg_pc, cfg_sp;

    exec_result_t pending_results [$];
    prog_row_t    dir_rows [DIR_ROWS];

    int  err_count;
    int  words_sent;
    int  words_checked;
    int  restarts_sent;
    int  idle_cycles;
    bit  quiet;
    int  stall_left;

    localparam logic [5:0] FN_LIST [17] = '{msie_pkg::FN_SLL, msie_pkg::FN_SRL,
        msie_pkg::FN_SRA, msie_pkg::FN_JR, msie_pkg::FN_MFHI, msie_pkg::FN_MFLO,
        msie_pkg::FN_MULT, msie_pkg::FN_MULTU, msie_pkg::FN_ADD, msie_pkg::FN_ADDU,
        msie_pkg::FN_SUB, msie_pkg::FN_AND, msie_pkg::FN_OR, msie_pkg::FN_XOR,
        msie_pkg::FN_NOR, msie_pkg::FN_NAND, msie_pkg::FN_SLT};
    localparam logic [5:0] OP_LIST [21] = '{msie_pkg::OP_J, msie_pkg::OP_JAL,
        msie_pkg::OP_BEQ, msie_pkg::OP_BNE, msie_pkg::OP_BGTZ, msie_pkg::OP_ADDI,
        msie_pkg::OP_ADDIU, msie_pkg::OP_SLTI, msie_pkg::OP_ANDI, msie_pkg::OP_ORI,
        msie_pkg::OP_NORI, msie_pkg::OP_LUI, msie_pkg::OP_LB, msie_pkg::OP_LH,
        msie_pkg::OP_LW, msie_pkg::OP_LBU, msie_pkg::OP_LHU, msie_pkg::OP_SB,
        msie_pkg::OP_SH, msie_pkg::OP_SW, msie_pkg::OP_HALT};

    // Clock.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Big-endian read of n bytes; each byte address wraps on its own.
    function automatic logic [31:0] mem_rd(logic [31:0] a, int n);
        logic [31:0] v;
        logic [31:0] t;
        v = '0;
        for (int i = 0; i < n; i++) begin
            t = a + i;
            v = {v[23:0], dmem[t % msie_pkg::MEM_BYTES]};
        end
        return v;
    endfunction

    task automatic mem_wr(logic [31:0] a, int n, logic [31:0] v);
        logic [31:0] t;
        logic [31:0] s;
        for (int i = 0; i < n; i++) begin
            t = a + i;
            s = v >> (8 * (n - 1 - i));
            dmem[t % msie_pkg::MEM_BYTES] = s[7:0];
        end
    endtask

    task automatic set_reg(logic [4:0] idx, logic [31:0] v, inout logic [33:0] msk);
        if (idx != 5'd0) begin
            if (gpr[idx] != v)
                msk[idx] = 1'b1;
            gpr[idx] = v;
        end
    endtask

    task automatic set_hilo(logic [63:0] p, inout logic [33:0] msk);
        if (p[63:32] != hi_q) msk[32] = 1'b1;
        if (p[31:0] != lo_q) msk[33] = 1'b1;
        hi_q = p[63:32];
        lo_q = p[31:0];
    endtask

    // Runs one instruction; ok is cleared for an undefined opcode or function.
    task automatic run_insn(logic [31:0] w, output logic ok, output logic [33:0] msk);
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] a, b, simm, zimm, ea, npc, v;
        op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
        sh = w[10:6]; fn = w[5:0];
        a = gpr[rs]; b = gpr[rt];
        zimm = {16'h0, w[15:0]};
        simm = {{16{w[15]}}, w[15:0]};
        ea = a + simm;
        npc = pc_q + 32'd4;
        ok = 1'b1;
        msk = '0;
        if (op == msie_pkg::OP_RTYPE) begin
            case (fn)
                msie_pkg::FN_ADD, msie_pkg::FN_ADDU: set_reg(rd, a + b, msk);
                msie_pkg::FN_SUB:   set_reg(rd, a - b, msk);
                msie_pkg::FN_AND:   set_reg(rd, a & b, msk);
                msie_pkg::FN_OR:    set_reg(rd, a | b, msk);
                msie_pkg::FN_XOR:   set_reg(rd, a ^ b, msk);
                msie_pkg::FN_NOR:   set_reg(rd, ~(a | b), msk);
                msie_pkg::FN_NAND:  set_reg(rd, ~(a & b), msk);
                msie_pkg::FN_SLT:   set_reg(rd, {31'h0, $signed(a) < $signed(b)}, msk);
                msie_pkg::FN_SLL:   set_reg(rd, b << sh, msk);
                msie_pkg::FN_SRL:   set_reg(rd, b >> sh, msk);
                msie_pkg::FN_SRA:   set_reg(rd, 32'($signed(b) >>> sh), msk);
                msie_pkg::FN_JR:    npc = a;
                msie_pkg::FN_MULT:  set_hilo({{32{a[31]}}, a} * {{32{b[31]}}, b}, msk);
                msie_pkg::FN_MULTU: set_hilo({32'h0, a} * {32'h0, b}, msk);
                msie_pkg::FN_MFHI:  set_reg(rd, hi_q, msk);
                msie_pkg::FN_MFLO:  set_reg(rd, lo_q, msk);
                default:            ok = 1'b0;
            endcase
        end else begin
            case (op)
                msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU: set_reg(rt, a + simm, msk);
                msie_pkg::OP_LW:  set_reg(rt, mem_rd(ea, 4), msk);
                msie_pkg::OP_LH:
                begin
                    v = mem_rd(ea, 2);
                    set_reg(rt, {{16{v[15]}}, v[15:0]}, msk);
                end
                msie_pkg::OP_LHU: set_reg(rt, mem_rd(ea, 2), msk);
                msie_pkg::OP_LB:
                begin
                    v = mem_rd(ea, 1);
                    set_reg(rt, {{24{v[7]}}, v[7:0]}, msk);
                end
                msie_pkg::OP_LBU:  set_reg(rt, mem_rd(ea, 1), msk);
                msie_pkg::OP_SW:   mem_wr(ea, 4, b);
                msie_pkg::OP_SH:   mem_wr(ea, 2, b);
                msie_pkg::OP_SB:   mem_wr(ea, 1, b);
                msie_pkg::OP_LUI:  set_reg(rt, {w[15:0], 16'h0}, msk);
                msie_pkg::OP_ANDI: set_reg(rt, a & zimm, msk);
                msie_pkg::OP_ORI:  set_reg(rt, a | zimm, msk);
                msie_pkg::OP_NORI: set_reg(rt, ~(a | zimm), msk);
                msie_pkg::OP_SLTI: set_reg(rt, {31'h0, $signed(a) < $signed(simm)}, msk);
                msie_pkg::OP_BEQ:  if (a == b) npc = npc + (simm << 2);
                msie_pkg::OP_BNE:  if (a != b) npc = npc + (simm << 2);
                msie_pkg::OP_BGTZ: if ($signed(a) > 0) npc = npc + (simm << 2);
                msie_pkg::OP_J:
                    npc = (npc & msie_pkg::PC_TOP_MASK) | {4'h0, w[25:0], 2'b00};
                msie_pkg::OP_JAL:
                begin
                    set_reg(msie_pkg::REG_RA, npc, msk);
                    npc = (npc & msie_pkg::PC_TOP_MASK) | {4'h0, w[25:0], 2'b00};
                end
                msie_pkg::OP_HALT: st_halt = 1'b1;
                default: ok = 1'b0;
            endcase
        end
        if (ok)
            pc_q = npc;
    endtask

    // Advances the predicted machine by one word and returns its result.
    task automatic predict_exec(logic [1:0] m, logic [31:0] w, logic [9:0] pa,
                                output exec_result_t r);
        logic        ok;
        logic [33:0] msk;
        msk = '0;
        case (m)
            msie_pkg::MODE_EXEC:
            begin
                if (!st_halt && !st_ill) begin
                    run_insn(w, ok, msk);
                    if (!ok) begin
                        st_ill = 1'b1;
                        msk = '0;
                    end
                end
            end
            msie_pkg::MODE_PRELOAD: mem_wr({22'h0, pa[9:2], 2'b00}, 4, w);
            msie_pkg::MODE_RESTART:
            begin
                for (int i = 0; i < 32; i++)
                    gpr[i] = '0;
                gpr[msie_pkg::REG_SP] = cfg_sp;
                hi_q = '0;
                lo_q = '0;
                pc_q = cfg_pc;
                st_halt = 1'b0;
                st_ill = 1'b0;
            end
            default: ;
        endcase
        r.pc = pc_q;
        r.msk = msk;
        r.h = st_halt;
        r.il = st_ill;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Sends one word with an optional random gap ahead of it.
    task automatic send_word(logic [1:0] m, logic [31:0] w, logic [9:0] pa,
                             logic typed, exec_result_t texp);
        exec_result_t r;
        if (!quiet && ($urandom % 6 == 0)) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        word <= w;
        preload_address <= pa;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_exec(m, w, pa, r);
        pending_results.push_back(typed ? texp : r);
        words_sent++;
        if (m == msie_pkg::MODE_RESTART)
            restarts_sent++;
    endtask

    // A random well-formed instruction of any supported kind.
    function automatic logic [31:0] rand_insn();
        logic [4:0]  rs, rt, rd;
        logic [15:0] imm;
        logic [5:0]  op;
        rs = 5'($urandom); rt = 5'($urandom); rd = 5'($urandom);
        imm = ($urandom % 2) ? 16'($urandom) : 16'($urandom_range(0, 40));
        if ($urandom % 2) begin
            return {msie_pkg::OP_RTYPE, rs, rt, rd, 5'($urandom), FN_LIST[$urandom % 17]};
        end
        op = OP_LIST[$urandom % 21];
        if (op == msie_pkg::OP_HALT && ($urandom % 3 != 0))
            op = msie_pkg::OP_ORI;
        if ((op >= msie_pkg::OP_LB) && ($urandom % 2))
            rs = 5'd0;
        if (op == msie_pkg::OP_J || op == msie_pkg::OP_JAL)
            return {op, 26'($urandom)};
        return {op, rs, rt, imm};
    endfunction

    task automatic send_random();
        int pick;
        pick = $urandom % 100;
        if ((st_halt || st_ill) && ($urandom % 3 == 0))
            pick = 0;
        if (pick < 4)
            send_word(msie_pkg::MODE_RESTART, $urandom, 10'($urandom), 1'b0, '0);
        else if (pick < 14)
            send_word(msie_pkg::MODE_PRELOAD, $urandom, 10'($urandom), 1'b0, '0);
        else if (pick < 16)
            send_word(msie_pkg::MODE_NONE, $urandom, 10'($urandom), 1'b0, '0);
        else if (pick < 20)
            send_word(msie_pkg::MODE_EXEC, $urandom, 10'($urandom), 1'b0, '0);
        else
            send_word(msie_pkg::MODE_EXEC, rand_insn(), 10'($urandom), 1'b0, '0);
    endtask

    // Sender pause: wait until every expected word has come back.
    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_start(logic [31:0] pcv, logic [31:0] spv);
        cfg_write <= 1'b1;
        cfg_index <= msie_pkg::CFG_START_PC;
        cfg_data <= pcv;
        @(posedge clk);
        cfg_index <= msie_pkg::CFG_START_SP;
        cfg_data <= spv;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_pc = pcv;
        cfg_sp = spv;
    endtask

    // Receiver stalls in random bursts.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (!quiet && ($urandom % 10 == 0)) begin
            stall_left = $urandom_range(1, 16) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin : result_check
        exec_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result pc", 64'(next_pc), 64'd0);
            end else begin
                e = pending_results.pop_front();
                words_checked++;
                if (next_pc !== e.pc)
                    report_mismatch("next_pc", 64'(next_pc), 64'(e.pc));
                if (changed_mask !== e.msk)
                    report_mismatch("changed_mask", 64'(changed_mask), 64'(e.msk));
                if (halted !== e.h)
                    report_mismatch("halted", 64'(halted), 64'(e.h));
                if (illegal !== e.il)
                    report_mismatch("illegal", 64'(illegal), 64'(e.il));
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        err_count = 0; words_sent = 0; words_checked = 0; restarts_sent = 0;
        idle_cycles = 0; quiet = 1'b0; stall_left = 0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0; cfg_index <= msie_pkg::CFG_START_PC; cfg_data <= '0;
        in_valid <= 1'b0; mode <= msie_pkg::MODE_EXEC; word <= '0;
        preload_address <= '0;
        out_stall <= 1'b0;
        for (int i = 0; i < 32; i++)
            gpr[i] = '0;
        for (int i = 0; i < msie_pkg::MEM_BYTES; i++)
            dmem[i] = '0;
        hi_q = '0; lo_q = '0; pc_q = '0;
        st_halt = 1'b0; st_ill = 1'b0;
        cfg_pc = '0; cfg_sp = '0;

        // Directed program: extremes, all non-branch classes, wrap and stop cases.
        dir_rows = '{
            '{msie_pkg::MODE_PRELOAD, 32'h8000_007F, 10'h3FF, 1'b1, '{32'h0, 34'h0, 1'b0, 1'b0}},
            '{msie_pkg::MODE_NONE, 32'hFFFF_FFFF, 10'h3FF, 1'b1, '{32'h0, 34'h0, 1'b0, 1'b0}},
            '{msie_pkg::MODE_EXEC, 32'h3C01_FFFF, 10'h0, 1'b1, '{32'h4, 34'h2, 1'b0, 1'b0}},
            '{msie_pkg::MODE_EXEC, 32'h3402_FFFF, 10'h0, 1'b1, '{32'h8, 34'h4, 1'b0, 1'b0}},
            '{msie_pkg::MODE_EXEC, 32'h0022_1820, 10'h0, 1'b1, '{32'hC, 34'h8, 1'b0, 1'b0}},
            '{msie_pkg::MODE_EXEC, 32'h2064_0001, 10'h0, 1'b1, '{32'h10, 34'h0, 1'b0, 1'b0}},
            '{msie_pkg::MODE_EXEC, 32'h3C05_8000, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h20A6_FFFF, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h8C07_03FC, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h8008_03FF, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h9009_03FC, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h840A_03FF, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h940B_03FC, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'hAC03_03FE, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h00A3_0018, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h00A3_0019, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h0000_6010, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h0000_6812, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h0005_77C3, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h0022_8828, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h00A0_902A, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h0FFF_FFFF, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h03E0_0008, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h0400_0000, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_EXEC, 32'h3C01_FFFF, 10'h0, 1'b0, '0},
            '{msie_pkg::MODE_RESTART, 32'h0, 10'h0, 1'b1, '{32'h0, 34'h0, 1'b0, 1'b0}},
            '{msie_pkg::MODE_EXEC, 32'hFC00_0000, 10'h0, 1'b1, '{32'h4, 34'h0, 1'b1, 1'b0}},
            '{msie_pkg::MODE_PRELOAD, 32'h1234_5678, 10'h001, 1'b0, '0},
            '{msie_pkg::MODE_RESTART, 32'h0, 10'h0, 1'b0, '0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_start(32'h0, 32'h0);

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i].m, dir_rows[i].w, dir_rows[i].pa,
                      dir_rows[i].typed, dir_rows[i].r);
        in_valid <= 1'b0;

        // Random phases, each under its own start PC and stack pointer.
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: write_start(32'hFFFF_FFFC, 32'hFFFF_FFFF);
                1: write_start($urandom, $urandom);
                2: write_start(32'h0000_0000, 32'h0000_0400);
                default: write_start({22'd0, 8'($urandom_range(0, 255)), 2'b00}, $urandom);
            endcase
            if (ph == 3)
                quiet = 1'b1;
            send_word(msie_pkg::MODE_RESTART, $urandom, 10'($urandom), 1'b0, '0);
            repeat (PHASE_ITEMS)
                send_random();
            in_valid <= 1'b0;
        end

        drain();
        repeat (16) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never returned", 64'(pending_results.size()), 64'd0);
        $display("Sent %0d words (%0d restarts), checked %0d results, %0d mismatches.",
                 words_sent, restarts_sent, words_checked, err_count);
        $display("Covered all opcodes, wrapped memory access, stop states and 5 start settings.");
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
